// ===== design/rcf_pkg.sv =====
package rcf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_W     = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CNT_W      = SIZE_W + 1;
  localparam int KROW_W     = 15;
  localparam int COEF_W     = 5;
  localparam int DIV_W      = 8;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_LANES  = 3;
  localparam int TAPS       = 9;
  localparam int PIX_W      = 24;

  localparam logic [KROW_W-1:0] KTOP_RST = 15'd1089;
  localparam logic [KROW_W-1:0] KMID_RST = 15'd2178;
  localparam logic [KROW_W-1:0] KBOT_RST = 15'd1089;
  localparam logic [DIV_W-1:0]  DIV_RST  = 8'd16;
  localparam logic [SIZE_W-1:0] FW_RST   = 11'd640;
  localparam logic [SIZE_W-1:0] FH_RST   = 11'd480;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KTOP   = 3'd0,
    REG_KMID   = 3'd1,
    REG_KBOT   = 3'd2,
    REG_DIV    = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_chan0;
    logic [7:0] in_chan1;
    logic [7:0] in_chan2;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_chan0;
    logic [7:0] out_chan1;
    logic [7:0] out_chan2;
    logic       frame_last;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } ls_wr_t;

endpackage

// ===== design/rcf_line_store.sv =====
module rcf_line_store (
  input  logic                      clk,
  input  logic [rcf_pkg::COL_W-1:0] rd_addr,
  input  rcf_pkg::ls_wr_t           wr,
  output logic [rcf_pkg::PIX_W-1:0] rd_upper,
  output logic [rcf_pkg::PIX_W-1:0] rd_lower
);

  logic [rcf_pkg::PIX_W-1:0] upper_mem [rcf_pkg::MAX_WIDTH];
  logic [rcf_pkg::PIX_W-1:0] lower_mem [rcf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_mem[wr.addr] <= wr.upper;
      lower_mem[wr.addr] <= wr.lower;
    end
    rd_upper <= upper_mem[rd_addr];
    rd_lower <= lower_mem[rd_addr];
  end

endmodule

// ===== design/rcf_lane.sv =====
module rcf_lane (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [rcf_pkg::TAPS-1:0][7:0]                pix,
  input  logic [rcf_pkg::TAPS-1:0][rcf_pkg::COEF_W-1:0] coef,
  input  logic [rcf_pkg::DIV_W-1:0]                    divisor,
  output logic                                         done,
  output logic [7:0]                                   result
);

  typedef enum logic [1:0] {L_IDLE, L_SUM, L_SAT, L_DIV} lane_state_t;

  lane_state_t        state_r;
  logic signed [13:0] prod_r [rcf_pkg::TAPS];
  logic signed [17:0] sum_w;
  logic [15:0]        rem_r;
  logic [7:0]         q_r;
  logic [2:0]         bit_r;
  logic               done_r;
  logic [rcf_pkg::DIV_W-1:0] dv;
  logic [15:0]        trial;

  assign dv    = (divisor == '0) ? rcf_pkg::DIV_W'(1) : divisor;
  assign trial = 16'(dv) << bit_r;

  // adder tree over the registered products
  always_comb begin
    sum_w = '0;
    for (int i = 0; i < rcf_pkg::TAPS; i++) begin
      sum_w = sum_w + 18'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == L_DIV) && (bit_r == 3'd0);
      case (state_r)
        L_IDLE: begin
          if (start) begin
            for (int i = 0; i < rcf_pkg::TAPS; i++) begin
              prod_r[i] <= $signed(coef[i]) * $signed({1'b0, pix[i]});
            end
            state_r <= L_SUM;
          end
        end
        L_SUM: begin
          rem_r   <= sum_w[17] ? 16'd0 : sum_w[15:0];
          state_r <= L_SAT;
        end
        L_SAT: begin
          bit_r   <= 3'd7;
          state_r <= L_DIV;
          // saturated: all ones, nothing left to subtract
          if (rem_r >= {dv, 8'h00}) begin
            q_r   <= 8'hFF;
            rem_r <= 16'd0;
          end else begin
            q_r <= '0;
          end
        end
        L_DIV: begin
          if (rem_r >= trial) begin
            rem_r        <= rem_r - trial;
            q_r[bit_r]   <= 1'b1;
          end
          if (bit_r == 3'd0) begin
            state_r <= L_IDLE;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

// ===== design/rgb_conv3x3_filter.sv =====
// channel | ports                              | direction | word
// in      | in_valid, in_ready, in_data        | input     | kind + three 8-bit channels
// out     | out_valid, out_ready, out_data     | output    | three 8-bit channels + frame_last
// cfg     | cfg_we, cfg_idx, cfg_data          | input     | register write, no wait
//
// a pixel word passes both store reads, then idles again when it yields no result; a border
// result goes on through calc and emit, an interior one through calc, the lanes and emit
// a flush word is ignored in idle, or drains a result through store read, select and emit
// the line stores use one shared read port, so a pixel reads two columns in turn
// reset (rst_n low, synchronous) restores the registers, positions and window
// a finished result waits in the output register; a new word is taken meanwhile
// and only a further result stalls until out_ready frees that register
module rgb_conv3x3_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rcf_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rcf_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDC, S_RDO, S_CALC, S_LANE, S_FRD, S_FSEL, S_EMIT
  } state_t;

  // configuration registers
  logic [rcf_pkg::KROW_W-1:0] ktop_r, kmid_r, kbot_r;
  logic [rcf_pkg::DIV_W-1:0]  div_r;
  logic [rcf_pkg::SIZE_W-1:0] fw_r, fh_r;
  logic [rcf_pkg::SIZE_W-1:0] size_in, size_clamped_w, size_clamped_h;

  // control
  state_t                     state_r;
  logic [rcf_pkg::COL_W-1:0]  ci_r, oc_r;
  logic [rcf_pkg::LINE_W-1:0] il_r, ol_r;
  logic [rcf_pkg::CNT_W-1:0]  cnt_r;
  logic                       out_valid_r;
  logic [rcf_pkg::PIX_W-1:0]  win_r [rcf_pkg::TAPS];

  // payload
  logic [rcf_pkg::PIX_W-1:0]  pix_r;
  logic [rcf_pkg::PIX_W-1:0]  res_r;
  rcf_pkg::out_word_t         out_r;

  // line stores
  logic [rcf_pkg::COL_W-1:0]  rd_addr;
  rcf_pkg::ls_wr_t            ls_wr;
  logic [rcf_pkg::PIX_W-1:0]  up_q, lo_q;

  // lanes
  logic [rcf_pkg::TAPS-1:0][rcf_pkg::COEF_W-1:0] coef_w;
  logic [rcf_pkg::NUM_LANES-1:0]                 lane_done;
  logic [rcf_pkg::NUM_LANES-1:0][7:0]            lane_res;
  logic                                          lane_start;

  logic in_acc, out_free, border_w, emit_px, last_w;
  logic [rcf_pkg::SIZE_W-1:0] ci_inc, oc_inc, il_inc, ol_inc;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // frame size writes clamp to 3..max
  assign size_in = cfg_data[rcf_pkg::SIZE_W-1:0];
  always_comb begin
    size_clamped_w = size_in;
    if (size_in < rcf_pkg::SIZE_MIN) size_clamped_w = rcf_pkg::SIZE_MIN;
    else if (size_in > rcf_pkg::SIZE_W'(rcf_pkg::MAX_WIDTH))
      size_clamped_w = rcf_pkg::SIZE_W'(rcf_pkg::MAX_WIDTH);
    size_clamped_h = size_in;
    if (size_in < rcf_pkg::SIZE_MIN) size_clamped_h = rcf_pkg::SIZE_MIN;
    else if (size_in > rcf_pkg::SIZE_W'(rcf_pkg::MAX_HEIGHT))
      size_clamped_h = rcf_pkg::SIZE_W'(rcf_pkg::MAX_HEIGHT);
  end

  // position arithmetic
  assign ci_inc = rcf_pkg::SIZE_W'(ci_r) + 1'b1;
  assign il_inc = rcf_pkg::SIZE_W'(il_r) + 1'b1;
  assign oc_inc = rcf_pkg::SIZE_W'(oc_r) + 1'b1;
  assign ol_inc = rcf_pkg::SIZE_W'(ol_r) + 1'b1;

  // output pixel on a frame edge passes through
  assign border_w = (oc_r == '0) || (ol_r == '0) || (oc_inc >= fw_r) || (ol_inc >= fh_r);
  assign last_w   = (ol_inc == fh_r) && (oc_inc == fw_r);

  // a pixel completes the lag of one line plus one pixel
  assign emit_px  = (cnt_r == rcf_pkg::CNT_W'(fw_r) + 1'b1);

  // one read address: new column first, output column second
  assign rd_addr = (state_r == S_RDC) ? ci_r : oc_r;

  always_comb begin
    ls_wr       = '0;
    ls_wr.en    = (state_r == S_RDO);
    ls_wr.addr  = ci_r;
    ls_wr.upper = lo_q;
    ls_wr.lower = pix_r;
  end

  rcf_line_store u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .wr       (ls_wr),
    .rd_upper (up_q),
    .rd_lower (lo_q)
  );

  // coefficient taps in window order, row by row, left first
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef_w[c]     = ktop_r[rcf_pkg::COEF_W*c +: rcf_pkg::COEF_W];
      coef_w[3 + c] = kmid_r[rcf_pkg::COEF_W*c +: rcf_pkg::COEF_W];
      coef_w[6 + c] = kbot_r[rcf_pkg::COEF_W*c +: rcf_pkg::COEF_W];
    end
  end

  assign lane_start = (state_r == S_CALC) && !border_w;

  // one lane per color channel
  for (genvar k = 0; k < rcf_pkg::NUM_LANES; k++) begin : g_lane
    logic [rcf_pkg::TAPS-1:0][7:0] lane_pix;
    always_comb begin
      for (int j = 0; j < rcf_pkg::TAPS; j++) begin
        lane_pix[j] = win_r[j][8*k +: 8];
      end
    end
    rcf_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (lane_start),
      .pix     (lane_pix),
      .coef    (coef_w),
      .divisor (div_r),
      .done    (lane_done[k]),
      .result  (lane_res[k])
    );
  end

  // control, window and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ktop_r      <= rcf_pkg::KTOP_RST;
      kmid_r      <= rcf_pkg::KMID_RST;
      kbot_r      <= rcf_pkg::KBOT_RST;
      div_r       <= rcf_pkg::DIV_RST;
      fw_r        <= rcf_pkg::FW_RST;
      fh_r        <= rcf_pkg::FH_RST;
      ci_r        <= '0;
      il_r        <= '0;
      oc_r        <= '0;
      ol_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < rcf_pkg::TAPS; j++) win_r[j] <= '0;
    end else begin
      // output register: loaded from the emit state, freed by out_ready
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.kind == rcf_pkg::KIND_PIXEL) begin
              state_r <= S_RDC;
            end else if (ci_r == '0 && il_r == '0 && cnt_r != '0) begin
              state_r <= S_FRD;
            end
          end
        end
        S_RDC: state_r <= S_RDO;
        S_RDO: begin
          // shift the window left, new column from the stores and the pixel
          for (int r = 0; r < 3; r++) begin
            win_r[3*r]     <= win_r[3*r + 1];
            win_r[3*r + 1] <= win_r[3*r + 2];
          end
          win_r[2] <= up_q;
          win_r[5] <= lo_q;
          win_r[8] <= pix_r;
          if (ci_inc >= fw_r) begin
            ci_r <= '0;
            il_r <= (il_inc >= fh_r) ? '0 : il_inc[rcf_pkg::LINE_W-1:0];
          end else begin
            ci_r <= ci_inc[rcf_pkg::COL_W-1:0];
          end
          if (emit_px) begin
            state_r <= S_CALC;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_CALC: state_r <= border_w ? S_EMIT : S_LANE;
        S_LANE: if (&lane_done) state_r <= S_EMIT;
        S_FRD:  state_r <= S_FSEL;
        S_FSEL: begin
          cnt_r   <= cnt_r - 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (oc_inc >= fw_r) begin
              oc_r <= '0;
              ol_r <= (ol_inc >= fh_r) ? '0 : ol_inc[rcf_pkg::LINE_W-1:0];
            end else begin
              oc_r <= oc_inc[rcf_pkg::COL_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_idx)
          rcf_pkg::REG_KTOP: ktop_r <= cfg_data;
          rcf_pkg::REG_KMID: kmid_r <= cfg_data;
          rcf_pkg::REG_KBOT: kbot_r <= cfg_data;
          rcf_pkg::REG_DIV:  div_r  <= cfg_data[rcf_pkg::DIV_W-1:0];
          rcf_pkg::REG_WIDTH, rcf_pkg::REG_HEIGHT: begin
            if (cfg_idx == rcf_pkg::REG_WIDTH) fw_r <= size_clamped_w;
            else                               fh_r <= size_clamped_h;
            // restart the frame, pending results dropped
            ci_r  <= '0;
            il_r  <= '0;
            oc_r  <= '0;
            ol_r  <= '0;
            cnt_r <= '0;
            for (int j = 0; j < rcf_pkg::TAPS; j++) win_r[j] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= {in_data.in_chan2, in_data.in_chan1, in_data.in_chan0};
    // border result from the older store: the pixel one line plus one back
    if (state_r == S_CALC) res_r <= up_q;
    // merge the three channel results
    if (state_r == S_LANE) res_r <= {lane_res[2], lane_res[1], lane_res[0]};
    // a drained pixel of the last line sits in the newer store, the one before it in the older
    if (state_r == S_FSEL) res_r <= (cnt_r <= rcf_pkg::CNT_W'(fw_r)) ? lo_q : up_q;
    if (state_r == S_EMIT && out_free) begin
      out_r.out_chan0  <= res_r[7:0];
      out_r.out_chan1  <= res_r[15:8];
      out_r.out_chan2  <= res_r[23:16];
      out_r.frame_last <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pending count never exceeds the lag of one line plus one pixel
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rcf_pkg::CNT_W'(fw_r) + 1'b1)
    else $error("pending count beyond line lag");

  // input column stays inside the frame
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcf_pkg::SIZE_W'(ci_r) < fw_r)
    else $error("input column outside frame");

  // the three lanes run in lockstep
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done == '0) || (&lane_done))
    else $error("lanes out of step");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> out_valid_r && $stable(out_r))
    else $error("output overwritten");

endmodule
